>>> src/trpg_pkg.sv
// Shared types and constants for the tone ramp pattern generator.
package trpg_pkg;

  localparam logic [7:0] LEVEL_CEIL  = 8'd239;
  localparam logic [7:0] LEVEL_FLOOR = 8'd16;
  localparam logic [7:0] SIDE_OFFSET = 8'd2;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690.
  localparam logic [12:0] PCT_RECIP = 13'd5243;
  localparam int          PCT_SHIFT = 19;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HIGH   = 3'd0,
    REG_START_LOW    = 3'd1,
    REG_HIGH_STEP    = 3'd2,
    REG_LOW_STEP     = 3'd3,
    REG_REPEAT_COUNT = 3'd4,
    REG_RAMP_STEPS   = 3'd5,
    REG_PLAT_STEPS   = 3'd6,
    REG_DUR_PERCENT  = 3'd7
  } reg_idx_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_NEXT  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    PH_UP      = 3'b001,
    PH_PLATEAU = 3'b010,
    PH_DOWN    = 3'b100
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] note_length;
  } in_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] pulse_duration;
    logic       last_pair;
  } out_t;

  typedef struct packed {
    logic       running;
    phase_t     phase;
    logic [7:0] steps_left;
    logic [7:0] repeats_left;
  } seq_t;

endpackage

>>> src/tone_ramp_pattern_generator_top.sv
// Top level of the tone ramp pattern generator: sequencer, level ramp and result register.
// The block takes one item per clock cycle while input ready is high, and shows each pair
// in the cycle after the transfer that caused it, from a single result register; a start
// item gives no transfer on the result side. Input ready stays high unless a result is held
// that the consumer has not taken. Every pair is worked out in one pass of logic from the
// sequencer state: a clamped add on one level and a clamped subtract on the other, a short
// phase advance of up to four steps, and one multiply by a reciprocal for the pulse duration.
module tone_ramp_pattern_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  trpg_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output trpg_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [trpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_wdata
);
  import trpg_pkg::*;

  logic [7:0]  start_high_r, start_low_r, high_step_r, low_step_r;
  logic [7:0]  repeat_count_r, ramp_steps_r, plat_steps_r;
  logic [6:0]  dur_percent_r;

  logic [7:0]  high_level_r, high_level_nxt;
  logic [7:0]  low_level_r, low_level_nxt;
  logic [7:0]  high_side_r, high_side_nxt;
  logic [7:0]  low_side_r, low_side_nxt;
  logic [14:0] held_prod_r, held_prod_nxt;
  seq_t        seq_r, seq_nxt;
  logic [2:0]  slot_r, slot_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic        in_fire;
  logic        ramp_step;
  logic [8:0]  sum_hi, sum_lo;
  logic [9:0]  dif_hi, dif_lo;
  logic [7:0]  high_new, low_new;
  logic [7:0]  level_sel;
  logic [27:0] dur_prod;
  seq_t        seq_start, seq_adv;

  function automatic seq_t settle(seq_t s, logic [7:0] ramp, logic [7:0] plat);
    seq_t r;
    r = s;
    if (ramp == 8'd0 && plat == 8'd0) begin
      r.running = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      if (r.running && r.steps_left == 8'd0) begin
        case (r.phase)
          PH_UP: begin
            r.phase      = PH_PLATEAU;
            r.steps_left = plat;
          end
          PH_PLATEAU: begin
            r.phase      = PH_DOWN;
            r.steps_left = ramp;
          end
          default: begin
            if (r.repeats_left != 8'd0) begin
              r.repeats_left = r.repeats_left - 8'd1;
            end
            if (r.repeats_left == 8'd0) begin
              r.running = 1'b0;
            end else begin
              r.phase      = PH_UP;
              r.steps_left = ramp;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_high_r   <= 8'd128;
      start_low_r    <= 8'd128;
      high_step_r    <= 8'd1;
      low_step_r     <= 8'd1;
      repeat_count_r <= 8'd1;
      ramp_steps_r   <= 8'd1;
      plat_steps_r   <= 8'd1;
      dur_percent_r  <= 7'd100;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START_HIGH:   start_high_r   <= cfg_wdata;
        REG_START_LOW:    start_low_r    <= cfg_wdata;
        REG_HIGH_STEP:    high_step_r    <= cfg_wdata;
        REG_LOW_STEP:     low_step_r     <= cfg_wdata;
        REG_REPEAT_COUNT: repeat_count_r <= cfg_wdata;
        REG_RAMP_STEPS:   ramp_steps_r   <= cfg_wdata;
        REG_PLAT_STEPS:   plat_steps_r   <= cfg_wdata;
        REG_DUR_PERCENT:  dur_percent_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_hi = {1'b0, high_level_r} + {1'b0, high_step_r};
    sum_lo = {1'b0, low_level_r} + {1'b0, low_step_r};
    dif_hi = {2'b00, high_level_r} - {2'b00, high_step_r};
    dif_lo = {2'b00, low_level_r} - {2'b00, low_step_r};

    if (seq_r.phase == PH_UP) begin
      high_new = (sum_hi > {1'b0, LEVEL_CEIL}) ? LEVEL_CEIL : sum_hi[7:0];
      low_new  = ($signed(dif_lo) < $signed({2'b00, LEVEL_FLOOR})) ? LEVEL_FLOOR
                                                                  : dif_lo[7:0];
    end else begin
      low_new  = (sum_lo > {1'b0, LEVEL_CEIL}) ? LEVEL_CEIL : sum_lo[7:0];
      high_new = ($signed(dif_hi) < $signed({2'b00, LEVEL_FLOOR})) ? LEVEL_FLOOR
                                                                   : dif_hi[7:0];
    end

    ramp_step = (slot_r == 3'd0) && (seq_r.phase != PH_PLATEAU);
    dur_prod  = {13'd0, held_prod_r} * {15'd0, PCT_RECIP};

    seq_start              = '0;
    seq_start.running      = (repeat_count_r != 8'd0);
    seq_start.phase        = PH_UP;
    seq_start.steps_left   = ramp_steps_r;
    seq_start.repeats_left = repeat_count_r;
    seq_start              = settle(seq_start, ramp_steps_r, plat_steps_r);

    seq_adv = seq_r;
    if (slot_r >= 3'd5) begin
      if (seq_adv.steps_left != 8'd0) begin
        seq_adv.steps_left = seq_adv.steps_left - 8'd1;
      end
      seq_adv = settle(seq_adv, ramp_steps_r, plat_steps_r);
    end

    high_level_nxt = high_level_r;
    low_level_nxt  = low_level_r;
    high_side_nxt  = high_side_r;
    low_side_nxt   = low_side_r;
    held_prod_nxt  = held_prod_r;
    seq_nxt        = seq_r;
    slot_nxt       = slot_r;
    level_sel      = high_level_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      if (in_data.action == ACT_START) begin
        high_level_nxt = start_high_r;
        low_level_nxt  = start_low_r;
        high_side_nxt  = 8'd1;
        low_side_nxt   = 8'd1;
        held_prod_nxt  = {7'd0, in_data.note_length} * {8'd0, dur_percent_r};
        seq_nxt        = seq_start;
        slot_nxt       = 3'd0;
      end else if (seq_r.running) begin
        if (ramp_step) begin
          high_level_nxt = high_new;
          low_level_nxt  = low_new;
          high_side_nxt  = high_new - SIDE_OFFSET;
          low_side_nxt   = low_new + SIDE_OFFSET;
        end
        case (slot_r)
          3'd1:    level_sel = high_side_nxt;
          3'd4:    level_sel = low_side_nxt;
          default: level_sel = high_level_nxt;
        endcase
        if (slot_r >= 3'd5) begin
          slot_nxt = 3'd0;
          seq_nxt  = seq_adv;
        end else begin
          slot_nxt = slot_r + 3'd1;
        end
        out_valid_nxt               = 1'b1;
        out_data_nxt.level          = level_sel;
        out_data_nxt.pulse_duration = dur_prod[PCT_SHIFT+7:PCT_SHIFT];
        out_data_nxt.last_pair      = !seq_nxt.running;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_level_r <= 8'd0;
      low_level_r  <= 8'd0;
      high_side_r  <= 8'd1;
      low_side_r   <= 8'd1;
      held_prod_r  <= 15'd0;
      seq_r        <= '{running: 1'b0, phase: PH_UP, steps_left: 8'd0,
                        repeats_left: 8'd0};
      slot_r       <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      high_level_r <= high_level_nxt;
      low_level_r  <= low_level_nxt;
      high_side_r  <= high_side_nxt;
      low_side_r   <= low_side_nxt;
      held_prod_r  <= held_prod_nxt;
      seq_r        <= seq_nxt;
      slot_r       <= slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
